// ===== design/tsms_pkg.sv =====
// tsms_pkg: shared codes and control types for the tuple store
// no dependencies
package tsms_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_TAKE   = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_UNDEF  = 2'd3;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // control broadcast to every cell
  typedef struct packed {
    logic ins;    // write the request into the cell at the fill position
    logic scan;   // advance the match bus one cell toward the head
    logic shift;  // close the gap left by a take
  } cell_ctrl_t;

endpackage

// ===== design/tsms_cell.sv =====
// tsms_cell: one stored tuple, its match logic and one stage of the match bus
// depends on tsms_pkg
module tsms_cell #(
  parameter int MAXF  = 8,
  parameter int IDW   = 64,
  parameter int CW    = 5
) (
  input  logic                   clk,
  input  tsms_pkg::cell_ctrl_t   ctrl,
  input  logic [CW-1:0]          pos,
  input  logic [CW-1:0]          count,
  input  logic [CW-1:0]          sel_pos,
  // request
  input  logic [IDW-1:0]         req_id,
  input  logic [3:0]             req_size,
  input  logic [MAXF*2-1:0]      req_types,
  input  logic [MAXF-1:0]        req_act,
  input  logic [MAXF*32-1:0]     req_values,
  // neighbor behind (younger)
  input  logic [IDW-1:0]         nb_id,
  input  logic [3:0]             nb_size,
  input  logic [MAXF*2-1:0]      nb_types,
  input  logic [MAXF*32-1:0]     nb_values,
  output logic [IDW-1:0]         own_id,
  output logic [3:0]             own_size,
  output logic [MAXF*2-1:0]      own_types,
  output logic [MAXF*32-1:0]     own_values,
  // match bus, flows toward cell 0
  input  logic                   bin_v,
  input  logic [3:0]             bin_size,
  input  logic [MAXF*2-1:0]      bin_types,
  input  logic [MAXF*32-1:0]     bin_values,
  input  logic [CW-1:0]          bin_pos,
  output logic                   bout_v,
  output logic [3:0]             bout_size,
  output logic [MAXF*2-1:0]      bout_types,
  output logic [MAXF*32-1:0]     bout_values,
  output logic [CW-1:0]          bout_pos
);

  logic [IDW-1:0]     id_r;
  logic [3:0]         size_r;
  logic [MAXF*2-1:0]  types_r;
  logic [MAXF*32-1:0] values_r;
  logic               bv_r;
  logic [3:0]         bsize_r;
  logic [MAXF*2-1:0]  btypes_r;
  logic [MAXF*32-1:0] bvalues_r;
  logic [CW-1:0]      bpos_r;
  logic               hit;
  logic               fields_ok;
  logic               ins_en;
  logic               shift_en;
  logic [CW:0]        last_pos;

  always_comb begin
    fields_ok = 1'b1;
    for (int i = 0; i < MAXF; i++) begin
      if (i < int'(size_r)) begin
        if (types_r[i*2 +: 2] != req_types[i*2 +: 2]) fields_ok = 1'b0;
        else if (req_act[i] && values_r[i*32 +: 32] != req_values[i*32 +: 32])
          fields_ok = 1'b0;
      end
    end
  end

  assign hit = (pos < count) && (id_r == req_id) && (size_r == req_size) && fields_ok;
  assign ins_en = ctrl.ins && (pos == count);
  assign last_pos = {1'b0, count} - {{CW{1'b0}}, 1'b1};
  assign shift_en = ctrl.shift && (pos >= sel_pos) && ({1'b0, pos} < last_pos);

  always_ff @(posedge clk) begin
    if (ins_en) begin
      id_r     <= req_id;
      size_r   <= req_size;
      types_r  <= req_types;
      values_r <= req_values;
    end else if (shift_en) begin
      id_r     <= nb_id;
      size_r   <= nb_size;
      types_r  <= nb_types;
      values_r <= nb_values;
    end
    if (ctrl.scan) begin
      if (hit) begin
        bv_r      <= 1'b1;
        bsize_r   <= size_r;
        btypes_r  <= types_r;
        bvalues_r <= values_r;
        bpos_r    <= pos;
      end else begin
        bv_r      <= bin_v;
        bsize_r   <= bin_size;
        btypes_r  <= bin_types;
        bvalues_r <= bin_values;
        bpos_r    <= bin_pos;
      end
    end
  end

  assign own_id      = id_r;
  assign own_size    = size_r;
  assign own_types   = types_r;
  assign own_values  = values_r;
  assign bout_v      = bv_r;
  assign bout_size   = bsize_r;
  assign bout_types  = btypes_r;
  assign bout_values = bvalues_r;
  assign bout_pos    = bpos_r;

endmodule

// ===== design/tuple_space_match_store_top.sv =====
// tuple_space_match_store_top: ordered tuple store with wildcard match
// depends on tsms_pkg and tsms_cell
//
// channel   dir  handshake           ports
// request   in   start & !busy       in_cmd .. in_last, one beat per field
// result    out  out_valid strobe    out_status .. out_last, one beat per field
//
// a field beat that is not last gives no result
// insert: the last beat leads to S_INS, which writes the cell unless the store is full and registers the result
// read/take: the match bus ripples through the chain of cells in S_SCAN, then S_EMIT
//   gives one result beat per matched field
// reset clears the fill count, field counter and sequencer; cell contents are
//   only read below the fill count
// the receiver cannot stall: each result beat is shown for exactly one cycle
module tuple_space_match_store_top #(
  parameter int TABLE_DEPTH = 16,
  parameter int MAX_FIELDS  = 8,
  parameter int ID_BYTES    = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic [63:0]        in_tuple_id,
  input  logic [3:0]         in_field_count,
  input  logic [1:0]         in_field_type,
  input  logic               in_field_is_actual,
  input  logic signed [31:0] in_field_value,
  input  logic               in_last,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [4:0]         out_index,
  output logic               out_field_valid,
  output logic [1:0]         out_type,
  output logic signed [31:0] out_value,
  output logic               out_last
);

  localparam int DEPTH = TABLE_DEPTH;
  localparam int MAXF  = MAX_FIELDS;
  localparam int IDW   = ID_BYTES * 8;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int FRW   = $clog2(MAXF + 1);
  localparam int FIW   = (MAXF > 1) ? $clog2(MAXF) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_NF   = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [FRW-1:0]      fr_r, fr_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       scnt_r, scnt_nxt;
  logic [FIW-1:0]      fcnt_r, fcnt_nxt;

  // received request fields, kept across requests
  logic [1:0]          rq_t_r   [MAXF];
  logic                rq_a_r   [MAXF];
  logic [31:0]         rq_v_r   [MAXF];
  logic [1:0]          rq_t_nxt [MAXF];
  logic                rq_a_nxt [MAXF];
  logic [31:0]         rq_v_nxt [MAXF];

  // request as it takes part in the match
  logic [1:0]          cmd_r;
  logic [IDW-1:0]      eid_r;
  logic [3:0]          esize_r;
  logic [MAXF*2-1:0]   etypes_r, etypes_nxt;
  logic [MAXF-1:0]     eact_r, eact_nxt;
  logic [MAXF*32-1:0]  evalues_r, evalues_nxt;

  // selected tuple
  logic [3:0]          sel_size_r;
  logic [MAXF*2-1:0]   sel_types_r;
  logic [MAXF*32-1:0]  sel_values_r;
  logic [4:0]          sel_index_r;

  logic                ov_r;
  logic [1:0]          ost_r, ost_nxt;
  logic [4:0]          oidx_r, oidx_nxt;
  logic                ofv_r, ofv_nxt;
  logic [1:0]          oty_r, oty_nxt;
  logic [31:0]         oval_r, oval_nxt;
  logic                olast_r, olast_nxt;

  logic                accept;
  logic [3:0]          cnt_clamp;
  logic [FRW-1:0]      recv;
  logic                full;
  logic [4:0]          cnt_idx;
  logic [4:0]          take_idx;
  logic [4:0]          pos_idx;
  logic [4:0]          fnext;
  tsms_pkg::cell_ctrl_t ctrl;

  logic [IDW-1:0]      c_id     [DEPTH];
  logic [3:0]          c_size   [DEPTH];
  logic [MAXF*2-1:0]   c_types  [DEPTH];
  logic [MAXF*32-1:0]  c_values [DEPTH];
  logic                b_v      [DEPTH+1];
  logic [3:0]          b_size   [DEPTH+1];
  logic [MAXF*2-1:0]   b_types  [DEPTH+1];
  logic [MAXF*32-1:0]  b_values [DEPTH+1];
  logic [CW-1:0]       b_pos    [DEPTH+1];

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign full   = (cnt_r == CW'(DEPTH));

  // oversized counts clamp to the field capacity
  assign cnt_clamp = (int'(in_field_count) > MAXF) ? 4'(MAXF) : in_field_count;
  assign recv      = (int'(fr_r) < MAXF) ? fr_r + FRW'(1) : fr_r;

  // 5-bit views of wider or narrower counts
  logic [CW+4:0] cnt_ext, take_ext, pos_ext;
  assign cnt_ext  = {5'd0, cnt_r};
  assign take_ext = {5'd0, cnt_r - CW'(1)};
  assign pos_ext  = {5'd0, b_pos[0]};
  assign cnt_idx  = cnt_ext[4:0];
  assign take_idx = take_ext[4:0];
  assign pos_idx  = pos_ext[4:0];

  // store this beat's field, then form the effective request
  always_comb begin
    for (int i = 0; i < MAXF; i++) begin
      if (int'(fr_r) == i && i < int'(cnt_clamp)) begin
        rq_t_nxt[i] = in_field_type;
        rq_a_nxt[i] = in_field_is_actual;
        rq_v_nxt[i] = in_field_value;
      end else begin
        rq_t_nxt[i] = rq_t_r[i];
        rq_a_nxt[i] = rq_a_r[i];
        rq_v_nxt[i] = rq_v_r[i];
      end
      if (i < int'(cnt_clamp) && i < int'(recv)) begin
        etypes_nxt[i*2 +: 2]    = rq_t_nxt[i];
        eact_nxt[i]             = rq_a_nxt[i];
        evalues_nxt[i*32 +: 32] = rq_v_nxt[i];
      end else begin
        etypes_nxt[i*2 +: 2]    = 2'd0;
        eact_nxt[i]             = 1'b0;
        evalues_nxt[i*32 +: 32] = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAXF; i++) begin
        rq_t_r[i] <= rq_t_nxt[i];
        rq_a_r[i] <= rq_a_nxt[i];
        rq_v_r[i] <= rq_v_nxt[i];
      end
      if (in_last) begin
        cmd_r     <= in_cmd;
        eid_r     <= in_tuple_id[IDW-1:0];
        esize_r   <= cnt_clamp;
        etypes_r  <= etypes_nxt;
        eact_r    <= eact_nxt;
        evalues_r <= evalues_nxt;
      end
    end
  end

  assign fnext = {{(5-FIW){1'b0}}, fcnt_r} + 5'd1;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    fr_nxt    = fr_r;
    cnt_nxt   = cnt_r;
    scnt_nxt  = scnt_r;
    fcnt_nxt  = fcnt_r;
    ctrl      = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          fr_nxt = recv;
          if (in_last) begin
            fr_nxt   = '0;
            scnt_nxt = '0;
            case (in_cmd)
              tsms_pkg::CMD_INSERT: state_nxt = S_INS;
              tsms_pkg::CMD_TAKE,
              tsms_pkg::CMD_READ:   state_nxt = S_SCAN;
              default:              state_nxt = S_NF;
            endcase
          end
        end
      end
      S_INS: begin
        if (!full) begin
          ctrl.ins = 1'b1;
          cnt_nxt  = cnt_r + CW'(1);
        end
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (scnt_r == CW'(DEPTH)) begin
          if (!b_v[0]) begin
            state_nxt = S_NF;
          end else begin
            fcnt_nxt  = '0;
            state_nxt = S_EMIT;
            if (cmd_r == tsms_pkg::CMD_TAKE) begin
              ctrl.shift = 1'b1;
              cnt_nxt    = cnt_r - CW'(1);
            end
          end
        end else begin
          ctrl.scan = 1'b1;
          scnt_nxt  = scnt_r + CW'(1);
        end
      end
      S_EMIT: begin
        if (sel_size_r == 4'd0 || fnext == {1'b0, sel_size_r}) state_nxt = S_IDLE;
        else fcnt_nxt = fcnt_r + FIW'(1);
      end
      S_NF: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fr_r    <= '0;
      cnt_r   <= '0;
      scnt_r  <= '0;
      fcnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fr_r    <= fr_nxt;
      cnt_r   <= cnt_nxt;
      scnt_r  <= scnt_nxt;
      fcnt_r  <= fcnt_nxt;
      ov_r    <= (state_r == S_INS) || (state_r == S_NF) || (state_r == S_EMIT);
    end
  end

  // capture the oldest match when the bus has settled
  always_ff @(posedge clk) begin
    if (state_r == S_SCAN && scnt_r == CW'(DEPTH)) begin
      sel_size_r   <= b_size[0];
      sel_types_r  <= b_types[0];
      sel_values_r <= b_values[0];
      sel_index_r  <= (cmd_r == tsms_pkg::CMD_TAKE) ? take_idx : pos_idx;
    end
  end

  // result beat payload
  always_comb begin
    ost_nxt   = tsms_pkg::ST_NOT_FOUND;
    oidx_nxt  = 5'd0;
    ofv_nxt   = 1'b0;
    oty_nxt   = 2'd0;
    oval_nxt  = 32'd0;
    olast_nxt = 1'b1;
    case (state_r)
      S_INS: begin
        if (full) begin
          ost_nxt  = tsms_pkg::ST_FULL;
          oidx_nxt = cnt_idx;
        end else begin
          ost_nxt  = tsms_pkg::ST_INSERTED;
          oidx_nxt = cnt_idx + 5'd1;
        end
      end
      S_EMIT: begin
        ost_nxt  = tsms_pkg::ST_FOUND;
        oidx_nxt = sel_index_r;
        if (sel_size_r != 4'd0) begin
          ofv_nxt   = 1'b1;
          oty_nxt   = sel_types_r[fcnt_r*2 +: 2];
          oval_nxt  = sel_values_r[fcnt_r*32 +: 32];
          olast_nxt = (fnext == {1'b0, sel_size_r});
        end
      end
      default: begin
        ost_nxt = tsms_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ost_r   <= ost_nxt;
    oidx_r  <= oidx_nxt;
    ofv_r   <= ofv_nxt;
    oty_r   <= oty_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_index       = oidx_r;
  assign out_field_valid = ofv_r;
  assign out_type        = oty_r;
  assign out_value       = oval_r;
  assign out_last        = olast_r;

  // chain of cells; the bus enters empty behind the youngest cell
  assign b_v[DEPTH]      = 1'b0;
  assign b_size[DEPTH]   = '0;
  assign b_types[DEPTH]  = '0;
  assign b_values[DEPTH] = '0;
  assign b_pos[DEPTH]    = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [IDW-1:0]     nid;
    logic [3:0]         nsize;
    logic [MAXF*2-1:0]  ntypes;
    logic [MAXF*32-1:0] nvalues;
    if (g == DEPTH - 1) begin : g_tail
      assign nid = '0; assign nsize = '0; assign ntypes = '0; assign nvalues = '0;
    end else begin : g_mid
      assign nid     = c_id[g+1];
      assign nsize   = c_size[g+1];
      assign ntypes  = c_types[g+1];
      assign nvalues = c_values[g+1];
    end
    tsms_cell #(.MAXF(MAXF), .IDW(IDW), .CW(CW)) u_cell (
      .clk(clk), .ctrl(ctrl), .pos(CW'(g)), .count(cnt_r), .sel_pos(b_pos[0]),
      .req_id(eid_r), .req_size(esize_r), .req_types(etypes_r), .req_act(eact_r),
      .req_values(evalues_r),
      .nb_id(nid), .nb_size(nsize), .nb_types(ntypes), .nb_values(nvalues),
      .own_id(c_id[g]), .own_size(c_size[g]), .own_types(c_types[g]),
      .own_values(c_values[g]),
      .bin_v(b_v[g+1]), .bin_size(b_size[g+1]), .bin_types(b_types[g+1]),
      .bin_values(b_values[g+1]), .bin_pos(b_pos[g+1]),
      .bout_v(b_v[g]), .bout_size(b_size[g]), .bout_types(b_types[g]),
      .bout_values(b_values[g]), .bout_pos(b_pos[g])
    );
  end

  // fill count never passes the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("fill count beyond depth");

  // a field beat always reports found
  a_field_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field_valid |-> out_status == tsms_pkg::ST_FOUND)
    else $error("field beat without found status");

  // a take that hits leaves one tuple fewer
  a_take_dec: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.shift |=> cnt_r == $past(cnt_r) - CW'(1)) else $error("take count slip");

  // a result beat closes the request only when it is last
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && state_nxt == S_IDLE |=> out_valid && out_last)
    else $error("burst ended without last");

endmodule

// ===== tb/tuple_space_match_store_checker.sv =====
// tuple_space_match_store_checker: predicts and checks result beats of the tuple store
// depends on tsms_pkg; watches the request and result ports of the block
module tuple_space_match_store_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic [63:0]        in_tuple_id,
  input  logic [3:0]         in_field_count,
  input  logic [1:0]         in_field_type,
  input  logic               in_field_is_actual,
  input  logic signed [31:0] in_field_value,
  input  logic               in_last,
  input  logic               out_valid,
  input  logic [1:0]         out_status,
  input  logic [4:0]         out_index,
  input  logic               out_field_valid,
  input  logic [1:0]         out_type,
  input  logic signed [31:0] out_value,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending
);

  localparam int DEPTH = 16;
  localparam int NF    = 8;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  index;
    logic        fvalid;
    logic [1:0]  ftype;
    logic [31:0] fvalue;
    logic        flast;
  } result_beat_t;

  result_beat_t beat_queue[$];

  int          entry_count;
  logic [63:0] entry_id[DEPTH];
  int          entry_size[DEPTH];
  logic [1:0]  entry_type[DEPTH][NF];
  logic [31:0] entry_value[DEPTH][NF];
  logic [1:0]  req_type[NF];
  logic        req_actual[NF];
  logic [31:0] req_value[NF];
  int          recv_count;

  assign pending = beat_queue.size();

  function automatic result_beat_t mk(logic [1:0] s, int idx, logic v, logic [1:0] t,
                                      logic [31:0] val, logic l);
    result_beat_t b;
    b.status = s; b.index = idx[4:0]; b.fvalid = v; b.ftype = t;
    b.fvalue = val; b.flast = l;
    return b;
  endfunction

  task automatic emit_entry(int e, int idx);
    if (entry_size[e] == 0)
      beat_queue.push_back(mk(tsms_pkg::ST_FOUND, idx, 0, 0, 0, 1));
    else for (int i = 0; i < entry_size[e]; i++)
      beat_queue.push_back(mk(tsms_pkg::ST_FOUND, idx, 1, entry_type[e][i],
                              entry_value[e][i], i + 1 == entry_size[e]));
  endtask

  // apply one accepted request beat to the predicted store
  task automatic predict_beat();
    int cnt, rc, hit;
    logic [1:0]  rt[NF];
    logic        ra[NF];
    logic [31:0] rv[NF];
    logic ok;
    cnt = in_field_count > NF ? NF : int'(in_field_count);
    if (recv_count < cnt) begin
      req_type[recv_count]   = in_field_type;
      req_actual[recv_count] = in_field_is_actual;
      req_value[recv_count]  = in_field_value;
    end
    if (recv_count < NF) recv_count++;
    if (!in_last) return;
    rc = recv_count;
    recv_count = 0;
    for (int i = 0; i < NF; i++) begin
      rt[i] = (i < rc) ? req_type[i] : 2'd0;
      ra[i] = (i < rc) ? req_actual[i] : 1'b0;
      rv[i] = (i < rc) ? req_value[i] : 32'd0;
    end
    if (in_cmd == tsms_pkg::CMD_INSERT) begin
      if (entry_count >= DEPTH) begin
        beat_queue.push_back(mk(tsms_pkg::ST_FULL, entry_count, 0, 0, 0, 1));
      end else begin
        entry_id[entry_count] = in_tuple_id;
        entry_size[entry_count] = cnt;
        for (int i = 0; i < NF; i++) begin
          entry_type[entry_count][i]  = i < cnt ? rt[i] : 2'd0;
          entry_value[entry_count][i] = i < cnt ? rv[i] : 32'd0;
        end
        entry_count++;
        beat_queue.push_back(mk(tsms_pkg::ST_INSERTED, entry_count, 0, 0, 0, 1));
      end
      return;
    end
    hit = -1;
    if (in_cmd == tsms_pkg::CMD_TAKE || in_cmd == tsms_pkg::CMD_READ)
      for (int e = 0; e < entry_count && hit < 0; e++) begin
        ok = entry_id[e] == in_tuple_id && entry_size[e] == cnt;
        for (int i = 0; i < cnt; i++)
          if (entry_type[e][i] != rt[i] || (ra[i] && entry_value[e][i] != rv[i])) ok = 0;
        if (ok) hit = e;
      end
    if (hit < 0) begin
      beat_queue.push_back(mk(tsms_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 1));
    end else if (in_cmd == tsms_pkg::CMD_READ) begin
      emit_entry(hit, hit);
    end else begin
      emit_entry(hit, entry_count - 1);
      for (int j = hit; j + 1 < entry_count; j++) begin
        entry_id[j] = entry_id[j+1];
        entry_size[j] = entry_size[j+1];
        entry_type[j] = entry_type[j+1];
        entry_value[j] = entry_value[j+1];
      end
      entry_count--;
    end
  endtask

  always @(posedge clk) begin
    result_beat_t got, want;
    if (!rst_n) begin
      entry_count = 0;
      recv_count = 0;
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        got = mk(out_status, out_index, out_field_valid, out_type, out_value, out_last);
        if (beat_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result beat %h", got);
        end else begin
          want = beat_queue.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"mismatch: expected st=%0d idx=%0d fv=%0d ty=%0d val=%h last=%0d,",
                        " got st=%0d idx=%0d fv=%0d ty=%0d val=%h last=%0d"},
                       want.status, want.index, want.fvalid, want.ftype, want.fvalue,
                       want.flast, got.status, got.index, got.fvalid, got.ftype,
                       got.fvalue, got.flast);
          end
        end
      end
      if (start && !busy) predict_beat();
    end
  end
endmodule

// ===== tb/tuple_space_match_store_top_tb.sv =====
// tuple_space_match_store_top_tb: stimulus and verdict for the tuple store
// depends on tsms_pkg, tuple_space_match_store_top and tuple_space_match_store_checker
module tuple_space_match_store_top_tb;

  logic clk, rst_n, start, busy;
  logic [1:0]         in_cmd;
  logic [63:0]        in_tuple_id;
  logic [3:0]         in_field_count;
  logic [1:0]         in_field_type;
  logic               in_field_is_actual;
  logic signed [31:0] in_field_value;
  logic               in_last;
  logic               out_valid, out_field_valid, out_last;
  logic [1:0]         out_status, out_type;
  logic [4:0]         out_index;
  logic signed [31:0] out_value;
  int fail_count, pending;

  // small pools so reads and takes actually hit stored tuples
  logic [63:0] id_pool[4] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_6B65_7931,
                              64'h8000_0000_0000_0001};
  logic [31:0] val_pool[4] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

  tuple_space_match_store_top dut (.*);

  tuple_space_match_store_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // time limit: far beyond the slowest legal run
  initial begin
    #4000000;
    $display("tuple_space_match_store_top verification failed");
    $finish;
  end

  int burst_left;

  // one field beat; holds until accepted, gaps only between bursts
  task automatic send_beat(logic [1:0] c, logic [63:0] id, logic [3:0] n, logic [1:0] t,
                           logic a, logic [31:0] v, logic l);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start <= 1;
    in_cmd <= c; in_tuple_id <= id; in_field_count <= n; in_field_type <= t;
    in_field_is_actual <= a; in_field_value <= v; in_last <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // a whole request; beats gives how many items go on the wire
  task automatic send_req(logic [1:0] c, logic [63:0] id, int n, int beats, bit rnd_val);
    logic [31:0] v;
    for (int i = 0; i < beats; i++) begin
      v = rnd_val ? $urandom : val_pool[$urandom_range(0, 3)];
      send_beat(c, id, n[3:0], $urandom_range(0, 1) ? 2'd1 : 2'($urandom),
                $urandom_range(0, 1), v, i == beats - 1);
    end
  endtask

  int n;

  initial begin
    rst_n = 0; start = 0; in_cmd = 0; in_tuple_id = 0; in_field_count = 0;
    in_field_type = 0; in_field_is_actual = 0; in_field_value = 0; in_last = 0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty store miss, empty tuple, extremes, full store, missing and extra fields
    send_req(tsms_pkg::CMD_READ, id_pool[0], 0, 1, 0);
    send_req(tsms_pkg::CMD_INSERT, id_pool[0], 0, 1, 0);
    send_req(tsms_pkg::CMD_READ, id_pool[0], 0, 1, 0);
    send_beat(tsms_pkg::CMD_INSERT, id_pool[1], 4'd8, 2'd3, 1, 32'h8000_0000, 0);
    send_beat(tsms_pkg::CMD_INSERT, id_pool[1], 4'd8, 2'd0, 1, 32'h7FFF_FFFF, 1);
    send_req(tsms_pkg::CMD_INSERT, id_pool[2], 15, 10, 1);
    send_req(tsms_pkg::CMD_TAKE, id_pool[0], 0, 1, 0);
    send_req(tsms_pkg::CMD_UNDEF, id_pool[1], 8, 2, 0);
    send_req(tsms_pkg::CMD_TAKE, id_pool[1], 8, 2, 0);
    for (int i = 0; i < 17; i++) send_req(tsms_pkg::CMD_INSERT, id_pool[3], 1, 1, 0);
    send_req(tsms_pkg::CMD_TAKE, id_pool[3], 1, 1, 0);

    // random: mostly well-formed requests over small pools
    for (int k = 0; k < 160; k++) begin
      n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 3);
      send_req($urandom_range(0, 9) == 0 ? tsms_pkg::CMD_UNDEF : 2'($urandom_range(0, 2)),
               $urandom_range(0, 15) == 0 ? {$urandom, $urandom}
                                          : id_pool[$urandom_range(0, 3)],
               n, $urandom_range(0, 7) == 0 ? $urandom_range(1, 10)
                                            : (n == 0 ? 1 : (n > 8 ? 8 : n)),
               $urandom_range(0, 9) == 0);
    end

    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("tuple_space_match_store_top verification clean");
    else $display("tuple_space_match_store_top verification failed");
    $finish;
  end
endmodule
